[design/ldrt_pkg.sv]
// Shared constants and types for the longest distinct run tracker.
`default_nettype none

package ldrt_pkg;

    // Table geometry; the start slot mask assumes a power-of-two depth
    localparam int TABLE_DEPTH = 8192;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int PROBE_W     = ADDR_W + 1;

    // Sequence length limit and position widths
    localparam int MAX_ITEMS = 1048576;
    localparam int LPOS_W    = $clog2(MAX_ITEMS);
    localparam int POS_W     = LPOS_W + 1;

    // Field widths
    localparam int VALUE_W  = 31;
    localparam int LEN_W    = 21;
    localparam int STATUS_W = 2;

    // Sequence tag kept with each table entry
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    // Hash mixing constants
    localparam logic [31:0] HASH_C1 = 32'h7ed5_5d16;
    localparam logic [31:0] HASH_C2 = 32'hd3a2_646c;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONG = 2'd2;

    // One table entry: valid for the current sequence when epoch matches
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [VALUE_W-1:0] key;
        logic [LPOS_W-1:0]  lpos;
    } entry_t;

endpackage

`default_nettype wire

[design/longest_distinct_run_tracker_unit.sv]
// Top level: longest run of distinct values over a hash table in block RAM.
//
// Input stream (s_*): one value per transaction; s_tuser marks the first item
// of a sequence and s_tlast its final item. Output stream (m_*): one result
// per final item, carrying the longest distinct run and a status code
// (ok, table full, sequence too long); the length reads zero on error.
//
// Each item passes through these steps when its value hits an empty or matching
// slot on the first probe: accept, length check and first hash stage, second hash
// stage with RAM read, compare and write back, best length and result update;
// every further slot walked by linear probing over the table RAM repeats the
// compare step. An item skipped after an error goes only through accept, length
// check and result update. A final item's result is registered in the last step.
//
// Table entries carry an 8-bit sequence tag instead of a valid bit. After
// reset, and on every 255th first item, a clearing pass writes all 8192
// entries with s_tready low. The result sits in an output
// register: while the receiver stalls, the next items are still accepted
// and processed; only a further final item waits for the register to free.
`default_nettype none

module longest_distinct_run_tracker_unit
    import ldrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] value, [31] zero
    input  wire logic        s_tuser,   // [0] first
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] longest, [23:21] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_HASH  = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    // Table RAM
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Control and datapath registers
    logic [2:0]          state_reg, state_next;
    logic                resume_reg, resume_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   probe_addr_reg, probe_addr_next;
    logic [PROBE_W-1:0]  probe_cnt_reg, probe_cnt_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic                last_reg, last_next;
    logic [31:0]         hash_reg, hash_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic [LEN_W-1:0]    run_reg, run_next;
    logic [LEN_W-1:0]    best_reg, best_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic                m_valid_reg, m_valid_next;
    logic [LEN_W-1:0]    m_len_reg, m_len_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;

    // Hash second stage and probe decode
    logic [31:0]       mix;
    logic [31:0]       mag;
    logic [ADDR_W-1:0] start_slot;
    logic              slot_live;
    logic              slot_hit;
    logic [POS_W-1:0]  run_base;
    logic [LEN_W-1:0]  best_max;

    assign mix        = (hash_reg + HASH_C2) ^ 32'($signed(hash_reg) >>> 9);
    assign mag        = mix[31] ? (32'd0 - mix) : mix;
    assign start_slot = mag[ADDR_W-1:0];
    assign slot_live  = (rd_data_reg.epoch == epoch_reg);
    assign slot_hit   = slot_live && (rd_data_reg.key == value_reg);
    assign run_base   = position_reg - POS_W'(run_reg);
    assign best_max   = (run_reg > best_reg) ? run_reg : best_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(24 - LEN_W){1'b0}}, m_len_reg};
    assign m_tuser  = m_status_reg;

    // Sequencer: clear sweep, hash, probe walk, write back, result
    always_comb
    begin
        state_next      = state_reg;
        resume_next     = resume_reg;
        epoch_next      = epoch_reg;
        clr_addr_next   = clr_addr_reg;
        probe_addr_next = probe_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        value_next      = value_reg;
        last_next       = last_reg;
        hash_next       = hash_reg;
        position_next   = position_reg;
        run_next        = run_reg;
        best_next       = best_reg;
        err_next        = err_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_len_next      = m_len_reg;
        m_status_next   = m_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = '{epoch: '0, key: '0, lpos: '0};
        mem_re          = 1'b0;
        mem_raddr       = start_slot;

        case (state_reg)
            S_CLEAR:
            begin
                // Write one entry per cycle with a tag no sequence uses
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    epoch_next = EPOCH_W'(1);
                    state_next = resume_reg ? S_CHECK : S_IDLE;
                end
            end
            S_IDLE:
            begin
                // Take a transaction; a first item opens a new sequence
                if (s_tvalid)
                begin
                    value_next = s_tdata[VALUE_W-1:0];
                    last_next  = s_tlast;
                    state_next = S_CHECK;
                    if (s_tuser)
                    begin
                        position_next = '0;
                        run_next      = '0;
                        best_next     = '0;
                        err_next      = ST_OK;
                        if (epoch_reg == EPOCH_MAX)
                        begin
                            clr_addr_next = '0;
                            resume_next   = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                // Skip after an error, flag an overlong sequence, else hash
                resume_next = 1'b0;
                hash_next   = ({1'b0, value_reg} + HASH_C1) + ({1'b0, value_reg} << 12);
                if (err_reg != ST_OK)
                begin
                    state_next = S_FIN;
                end
                else if (position_reg >= POS_W'(MAX_ITEMS))
                begin
                    err_next   = ST_LONG;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                // Read the start slot
                mem_re          = 1'b1;
                mem_raddr       = start_slot;
                probe_addr_next = start_slot;
                probe_cnt_next  = '0;
                state_next      = S_PROBE;
            end
            S_PROBE:
            begin
                if (!slot_live || slot_hit)
                begin
                    // Claim a free slot or refresh the match, then extend the run
                    mem_we    = 1'b1;
                    mem_waddr = probe_addr_reg;
                    mem_wdata = '{epoch: epoch_reg, key: value_reg,
                                  lpos: position_reg[LPOS_W-1:0]};
                    if (slot_hit && (run_base <= POS_W'(rd_data_reg.lpos)))
                        run_next = LEN_W'(position_reg - POS_W'(rd_data_reg.lpos));
                    else
                        run_next = run_reg + 1'b1;
                    position_next = position_reg + 1'b1;
                    state_next    = S_FIN;
                end
                else if (probe_cnt_reg == PROBE_W'(TABLE_DEPTH - 1))
                begin
                    // Every slot walked without a match
                    err_next   = ST_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    // Advance to the next slot, wrapping at the table end
                    mem_re          = 1'b1;
                    mem_raddr       = probe_addr_reg + 1'b1;
                    probe_addr_next = probe_addr_reg + 1'b1;
                    probe_cnt_next  = probe_cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                // Fold the run into the best length; emit on a final item
                best_next = best_max;
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_len_next    = (err_reg == ST_OK) ? best_max : '0;
                    m_status_next = err_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            resume_reg    <= 1'b0;
            epoch_reg     <= EPOCH_W'(1);
            clr_addr_reg  <= '0;
            position_reg  <= '0;
            run_reg       <= '0;
            best_reg      <= '0;
            err_reg       <= ST_OK;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resume_reg    <= resume_next;
            epoch_reg     <= epoch_next;
            clr_addr_reg  <= clr_addr_next;
            position_reg  <= position_next;
            run_reg       <= run_next;
            best_reg      <= best_next;
            err_reg       <= err_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        probe_addr_reg <= probe_addr_next;
        probe_cnt_reg  <= probe_cnt_next;
        value_reg      <= value_next;
        last_reg       <= last_next;
        hash_reg       <= hash_next;
        m_len_reg      <= m_len_next;
        m_status_reg   <= m_status_next;
    end

    // Table RAM with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // An error result reports zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
        else $error("error result with nonzero length");

    // The sequencer never reads and writes the table in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table read and write overlap");

    // The run never outgrows the items taken so far
    assert property (@(posedge clk) disable iff (!rst_n)
        POS_W'(run_reg) <= position_reg)
        else $error("run length exceeds position");

    // Position stops at the sequence limit
    assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= POS_W'(MAX_ITEMS))
        else $error("position beyond limit");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the longest distinct run tracker unit.
`timescale 1ns / 100ps

module tb_top
    import ldrt_pkg::*;
();

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam int N_RANDOM_ITEMS = 1900;
    localparam int POOL_SIZE      = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    // One expected result of a sequence
    typedef struct {
        logic [LEN_W-1:0]    longest;
        logic [STATUS_W-1:0] status;
    } run_result_t;

    run_result_t run_results_due[$];
    int n_fail = 0;

    // Tracker state mirrored by the predictor
    bit                  slot_taken   [TABLE_DEPTH];
    logic [VALUE_W-1:0]  slot_key     [TABLE_DEPTH];
    int unsigned         slot_seen_at [TABLE_DEPTH];
    int unsigned         seq_pos = 0;
    int unsigned         cur_run = 0;
    int unsigned         best_run = 0;
    int unsigned         slots_filled = 0;
    logic [STATUS_W-1:0] seq_status = ST_OK;

    // Colliding values whose start slots sit near the table wrap
    logic [VALUE_W-1:0] collide_pool[$];

    // Idling controls
    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    int rx_hold_left = 0;
    int rx_stall_left = 0;

    always #5 clk = ~clk;

    longest_distinct_run_tracker_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [30:0] value, [31] zero
        .s_tuser  (s_tuser),    // [0] first
        .s_tlast  (s_tlast),    // last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [20:0] longest, [23:21] zero
        .m_tuser  (m_tuser)     // [1:0] status
    );

    // Start slot: wrapping add/shift mix, then magnitude modulo the depth
    function automatic int unsigned start_slot_of(logic [VALUE_W-1:0] v);
        logic [31:0]        x;
        logic signed [31:0] sx;
        logic [31:0]        sh;
        logic [31:0]        mag;
        x = {1'b0, v} + HASH_C1 + ({1'b0, v} << 12);
        sx = x;
        sh = sx >>> 9;
        x = (x + HASH_C2) ^ sh;
        mag = x[31] ? (32'd0 - x) : x;
        return mag % TABLE_DEPTH;
    endfunction

    function automatic void clear_tracker();
        foreach (slot_taken[i])
            slot_taken[i] = 1'b0;
        seq_pos = 0;
        cur_run = 0;
        best_run = 0;
        slots_filled = 0;
        seq_status = ST_OK;
    endfunction

    // Probe for the value, record its position and extend or restart the run
    function automatic void absorb_value(logic [VALUE_W-1:0] v);
        int unsigned h;
        int unsigned n;
        int unsigned slot;
        int unsigned prev;
        bit          found;
        bit          placed;
        if (seq_pos >= MAX_ITEMS) begin
            seq_status = ST_LONG;
            return;
        end
        h = start_slot_of(v);
        found = 1'b0;
        placed = 1'b0;
        slot = 0;
        prev = 0;
        for (n = 0; n < TABLE_DEPTH && !found && !placed; n++) begin
            if (!slot_taken[h]) begin
                slot = h;
                placed = 1'b1;
            end
            else if (slot_key[h] == v) begin
                slot = h;
                found = 1'b1;
            end
            else
                h = (h + 1) % TABLE_DEPTH;
        end
        if (!found && !placed) begin
            seq_status = ST_FULL;
            return;
        end
        if (placed) begin
            slot_taken[slot] = 1'b1;
            slot_key[slot] = v;
            slots_filled++;
        end
        else
            prev = slot_seen_at[slot];
        slot_seen_at[slot] = seq_pos;
        if (!found || (seq_pos - cur_run) > prev)
            cur_run++;
        else
            cur_run = seq_pos - prev;
        if (cur_run > best_run)
            best_run = cur_run;
        seq_pos++;
    endfunction

    // Predict one accepted item; a final item queues its result
    function automatic void advance_run_tracker(logic [VALUE_W-1:0] v, bit first, bit last);
        run_result_t r;
        if (first)
            clear_tracker();
        if (seq_status == ST_OK)
            absorb_value(v);
        if (last) begin
            r.longest = (seq_status == ST_OK) ? best_run[LEN_W-1:0] : '0;
            r.status = seq_status;
            run_results_due.push_back(r);
        end
    endfunction

    // Search values whose start slot lies next to the table wrap
    function automatic void build_value_sets();
        int unsigned s;
        logic [31:0] v;
        v = '0;
        while (collide_pool.size() < POOL_SIZE && v < 32'h0100_0000) begin
            s = start_slot_of(v[VALUE_W-1:0]);
            if (s >= TABLE_DEPTH - 2 || s <= 1)
                collide_pool.push_back(v[VALUE_W-1:0]);
            v++;
        end
    endfunction

    // Compare one result transaction with the oldest expectation
    function automatic void check_result(logic [LEN_W-1:0] longest, logic [STATUS_W-1:0] status);
        run_result_t want;
        if (run_results_due.size() == 0) begin
            $error("unexpected result: longest %0d status %0d", longest, status);
            n_fail++;
            return;
        end
        want = run_results_due.pop_front();
        if (longest !== want.longest) begin
            $error("longest mismatch: expected %0d, actual %0d", want.longest, longest);
            n_fail++;
        end
        if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            n_fail++;
        end
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sample result transactions at the rising edge
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            check_result(m_tdata[LEN_W-1:0], m_tuser);

    // Drive the result ready: long hold-offs first, then random stalls
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (rx_hold_left > 0) begin
                m_tready = 1'b0;
                rx_hold_left--;
            end
            else if (rx_stall_left > 0) begin
                m_tready = 1'b0;
                rx_stall_left--;
            end
            else begin
                m_tready = 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0)
                    rx_stall_left = pick_gap();
            end
        end
    end

    // Offer one item from a falling edge and hold it until the transaction completes
    task automatic send_item(logic [VALUE_W-1:0] v, bit first, bit last);
        s_tdata = {1'b0, v};
        s_tuser = first;
        s_tlast = last;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        advance_run_tracker(v, first, last);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        int n;
        if (!tx_gaps_on || $urandom_range(0, 1) == 0)
            return;
        n = pick_gap();
        s_tvalid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (run_results_due.size() != 0)
            @(negedge clk);
    endtask

    // Build one sequence from a random alphabet or of fresh random values; some lack the first or last mark
    task automatic send_random_sequence(output int n_items);
        int                 len;
        int                 kind;
        int                 asz;
        int                 i;
        int                 r;
        bit                 with_first;
        bit                 with_last;
        logic [VALUE_W-1:0] alpha[$];
        logic [VALUE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(1, 12);
        else if (r < 95)
            len = $urandom_range(13, 60);
        else
            len = $urandom_range(100, 400);
        kind = $urandom_range(0, 3);
        asz = $urandom_range(1, len + 3);
        for (i = 0; i < asz; i++) begin
            case (kind)
                0: v = VALUE_W'($urandom());
                1: v = collide_pool[$urandom_range(0, POOL_SIZE - 1)];
                default: v = VALUE_W'($urandom_range(0, asz));
            endcase
            if ($urandom_range(0, 19) == 0)
                v = ($urandom_range(0, 1) != 0) ? VALUE_MAX : '0;
            alpha.push_back(v);
        end
        with_first = ($urandom_range(0, 9) != 0);
        with_last = ($urandom_range(0, 11) != 0);
        for (i = 0; i < len; i++) begin
            if (kind == 3)
                v = VALUE_W'($urandom());
            else
                v = alpha[$urandom_range(0, asz - 1)];
            send_item(v, with_first && i == 0, with_last && i == len - 1);
            sender_gap();
        end
        n_items = len;
    endtask

    // Reset-state start, continuation, single items, repeats, colliders, extremes
    task automatic test_directed();
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        send_item(31'd5, 1'b0, 1'b0);
        send_item(VALUE_MAX, 1'b0, 1'b0);
        send_item('0, 1'b0, 1'b1);
        send_item(31'd5, 1'b0, 1'b1);
        sender_gap();
        send_item('0, 1'b1, 1'b1);
        send_item(31'd1, 1'b1, 1'b0);
        send_item(31'd2, 1'b0, 1'b0);
        send_item(31'd3, 1'b0, 1'b0);
        sender_gap();
        send_item(31'd2, 1'b0, 1'b0);
        send_item(31'd4, 1'b0, 1'b0);
        send_item(31'd5, 1'b0, 1'b0);
        send_item(31'd1, 1'b0, 1'b1);
        send_item(collide_pool[0], 1'b1, 1'b0);
        send_item(collide_pool[1], 1'b0, 1'b0);
        send_item(collide_pool[2], 1'b0, 1'b0);
        send_item(collide_pool[0], 1'b0, 1'b0);
        send_item(collide_pool[3], 1'b0, 1'b0);
        send_item(collide_pool[1], 1'b0, 1'b1);
        send_item(VALUE_MAX, 1'b1, 1'b0);
        send_item(VALUE_MAX, 1'b0, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_sequences();
        int sent;
        int n;
        sent = 0;
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        while (sent < N_RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                tx_gaps_on = !tx_gaps_on;
            if ($urandom_range(0, 9) == 0)
                rx_stalls_on = !rx_stalls_on;
            send_random_sequence(n);
            sent += n;
        end
        wait_results_drained();
    endtask

    // Hold off the receiver while short sequences keep coming, so the input stalls
    task automatic test_output_backpressure();
        int i;
        int j;
        int len;
        tx_gaps_on = 1'b0;
        rx_hold_left = 600;
        for (i = 0; i < 40; i++) begin
            len = $urandom_range(1, 4);
            for (j = 0; j < len; j++)
                send_item(VALUE_W'($urandom_range(0, 3)), j == 0, j == len - 1);
        end
        wait_results_drained();
    endtask

    initial begin
        build_value_sets();
        clear_tracker();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_sequences();
        test_output_backpressure();

        // Let any stray result surface before the verdict
        s_tvalid = 1'b0;
        wait_results_drained();
        repeat (200) @(negedge clk);
        if (run_results_due.size() != 0) begin
            $error("%0d expected results never arrived", run_results_due.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Stop a hung run
    initial begin
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
